// ===== design/polynomial_trajectory_interpolator_macros.svh =====
// Assertion macros for the trajectory interpolator.
`ifndef POLYNOMIAL_TRAJECTORY_INTERPOLATOR_MACROS_SVH
`define POLYNOMIAL_TRAJECTORY_INTERPOLATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PTI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PTI_ASSERT_IMP(lbl, ante, cons, msg)
`define PTI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/pti_pkg.sv =====
package pti_pkg;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 200;

    localparam logic [1:0] FUNC_WP    = 2'd0;
    localparam logic [1:0] FUNC_COEF  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_START  = 3'd2;
    localparam logic [2:0] REG_FINISH = 3'd3;
    localparam logic [2:0] REG_ENABLE = 3'd4;

    localparam logic [1:0] MODE_SPLINE = 2'd0;
    localparam logic [3:0] POS_SLOT    = 4'd8;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T1, ST_T1W, ST_SRCH, ST_SA, ST_SB, ST_DT, ST_DTW,
        ST_EINIT, ST_EINITW, ST_ESTEP, ST_EMULW,
        ST_BQ0, ST_BQ0W, ST_BQFW, ST_BM, ST_BMW,
        ST_HRD, ST_HW, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic sh32;   // 1: shift product by 32, 0: by 16
    } t_mul_req;

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            r = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            r = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    // a * k, k small and non-negative, saturated
    function automatic logic signed [63:0] smulk(input logic signed [63:0] a,
                                                 input logic [5:0] k);
        logic signed [70:0] p;
        logic signed [70:0] ae;
        logic signed [70:0] ke;
        ae = 71'(a);
        ke = $signed({65'd0, k});
        p  = ae * ke;
        if (!((&p[70:63]) || !(|p[70:63]))) begin
            return p[70] ? S64_MIN : S64_MAX;
        end
        return p[63:0];
    endfunction

    // derivative factor of power k in chain ch: 1, k, k*(k-1)
    function automatic logic [5:0] deriv_mult(input logic [2:0] k, input logic [1:0] ch);
        logic [5:0] kk;
        kk = {3'd0, k};
        case (ch)
            2'd0: return 6'd1;
            2'd1: return kk;
            default: return kk * (kk - 6'd1);
        endcase
    endfunction

endpackage

// ===== design/pti_mul.sv =====
module pti_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pti_pkg::t_mul_req  i_req,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import pti_pkg::*;

    logic                r_run;
    logic                r_done;
    logic [2:0]          r_step;
    logic                r_neg;
    logic                r_sh32;
    logic [63:0]         r_ua;
    logic [63:0]         r_ub;
    logic signed [127:0] r_acc;
    logic signed [63:0]  r_res;

    logic [31:0]         ha;
    logic [31:0]         hb;
    logic [63:0]         pp;
    logic [1:0]          pp_sel;
    logic [127:0]        pp_sh;
    logic signed [127:0] sh;
    logic                fits;

    // one 32x32 partial product per step
    assign ha     = r_step[0] ? r_ua[63:32] : r_ua[31:0];
    assign hb     = r_step[1] ? r_ub[63:32] : r_ub[31:0];
    assign pp     = ha * hb;
    assign pp_sel = {1'b0, r_step[0]} + {1'b0, r_step[1]};
    assign pp_sh  = {64'd0, pp} << {pp_sel, 5'd0};

    assign sh   = r_sh32 ? (r_acc >>> 32) : (r_acc >>> 16);
    assign fits = (&sh[127:63]) || !(|sh[127:63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd5) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ua   <= i_a[63] ? 64'd0 - i_a : i_a;
            r_ub   <= i_b[63] ? 64'd0 - i_b : i_b;
            r_neg  <= i_a[63] ^ i_b[63];
            r_sh32 <= i_req.sh32;
            r_acc  <= '0;
        end else if (r_run) begin
            if (r_step < 3'd4) begin
                r_acc <= r_acc + $signed(pp_sh);
            end else if (r_step == 3'd4) begin
                if (r_neg) begin
                    r_acc <= -r_acc;
                end
            end else begin
                r_res <= fits ? sh[63:0] : (r_acc[127] ? S64_MIN : S64_MAX);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== design/polynomial_trajectory_interpolator.sv =====
// Write beats go into the stores as they are accepted. A query runs the segment
// search, then Horner steps on one shared multiplier that forms each product in steps
// (four 32x32 partial products, sign, shift/saturate).
// One query is in flight; the next beat is taken once it ends.
// Reset (sync, active low) loads register defaults and clears the segment; stores keep data.
`include "polynomial_trajectory_interpolator_macros.svh"

module polynomial_trajectory_interpolator #(
    parameter int MAX_WAYPOINTS = 64,
    parameter int AXES          = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot_index[5:0], axis[8:6], coef_slot[11:9], time_value[43:12], value[107:44]
    input  logic [pti_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // func[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // axis_out[2:0], position[66:3], velocity[130:67], acceleration[194:131]
    output logic [pti_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_we,
    input  logic [2:0]                       i_cfg_addr,
    input  logic [31:0]                      i_cfg_wdata
);
    import pti_pkg::*;

    localparam int WP_W     = $clog2(MAX_WAYPOINTS);
    localparam int AXW      = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int RW       = $clog2(MAX_WAYPOINTS * AXES);
    localparam int CAW      = RW + 4;
    localparam int CM_DEPTH = MAX_WAYPOINTS * AXES * 16;
    localparam int CNT_RAW  = $clog2(MAX_WAYPOINTS + 1);
    localparam int CMP_W    = (CNT_RAW > 7) ? CNT_RAW : 7;

    // ---------------- storage ----------------
    // Coefficient memory rows: one per (waypoint/segment, axis), 16 entries each:
    // powers 0..7 of the polynomial, entry 8 holds the waypoint position.
    logic [63:0] r_cm [CM_DEPTH];
    logic [31:0] r_tm [MAX_WAYPOINTS];   // waypoint time stamps
    logic [63:0] r_cm_rd;
    logic [31:0] r_tm_rd;

    // ---------------- configuration ----------------
    logic [1:0]         r_mode;
    logic [6:0]         r_count;
    logic signed [31:0] r_start;
    logic signed [31:0] r_finish;
    logic               r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SPLINE;
            r_count  <= 7'd2;
            r_start  <= '0;
            r_finish <= '0;
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:   r_mode   <= i_cfg_wdata[1:0];
                REG_COUNT:  r_count  <= i_cfg_wdata[6:0];
                REG_START:  r_start  <= i_cfg_wdata;
                REG_FINISH: r_finish <= i_cfg_wdata;
                REG_ENABLE: r_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- input fields ----------------
    logic [1:0]         in_func;
    logic [5:0]         in_slot;
    logic [2:0]         in_axis;
    logic [2:0]         in_cs;
    logic signed [31:0] in_time;
    logic [63:0]        in_value;

    assign in_func  = s_axis_tuser;
    assign in_slot  = s_axis_tdata[5:0];
    assign in_axis  = s_axis_tdata[8:6];
    assign in_cs    = s_axis_tdata[11:9];
    assign in_time  = s_axis_tdata[43:12];
    assign in_value = s_axis_tdata[107:44];

    // ---------------- sequencer state ----------------
    t_state             r_state, n_state;
    logic [WP_W-1:0]    r_cur_seg;     // remembered segment
    logic [WP_W-1:0]    r_seg;
    logic [AXW-1:0]     r_ax;
    logic [1:0]         r_ch;          // Horner chain: value, first, second derivative
    logic [2:0]         r_k;           // power last folded in
    logic [1:0]         r_j;           // blend output under scaling
    logic               r_hold;        // disabled or past finish time
    logic signed [32:0] r_t;           // query time relative to start
    logic signed [33:0] r_dt;          // time inside segment
    logic signed [31:0] r_wlo;
    logic signed [63:0] r_acc;
    logic signed [63:0] r_term;
    logic signed [63:0] r_q0;
    logic signed [63:0] r_dq;
    logic signed [63:0] r_poly [3];
    logic signed [63:0] r_o [3];

    logic               r_out_valid;
    logic [AXW-1:0]     r_out_ax;
    logic signed [63:0] r_out_p;
    logic signed [63:0] r_out_v;
    logic signed [63:0] r_out_a;
    logic               r_out_last;

    // ---------------- derived control ----------------
    logic              s_accept;
    logic              wr_ok;
    logic              cm_we;
    logic              tm_we;
    logic [CAW-1:0]    cm_waddr;
    logic [WP_W-1:0]   w_slot;
    logic              cm_re;
    logic [CAW-1:0]    cm_raddr;
    logic              tm_re;
    logic [WP_W-1:0]   tm_raddr;
    logic [CMP_W-1:0]  cnt_raw;
    logic [CMP_W-1:0]  cnt_c;
    logic [WP_W-1:0]   last_wp;
    logic [WP_W-1:0]   seg_max;       // index of the last segment
    logic [WP_W-1:0]   seg_clamp;
    logic [WP_W-1:0]   seg_nx;
    logic [2:0]        order_n;
    logic [RW-1:0]     cur_row;
    logic              use_poly;
    logic              out_free;
    logic              out_load;
    logic              last_ax;
    logic signed [32:0] wt_ext;
    t_mul_req           mul_req;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic               mul_done;
    logic signed [63:0] mul_res;

    function automatic logic [RW-1:0] row_of(input logic [WP_W-1:0] s,
                                             input logic [AXW-1:0] a);
        return RW'(s) * RW'(AXES) + RW'(a);
    endfunction

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign wr_ok    = (int'(in_slot) < MAX_WAYPOINTS) && (int'(in_axis) < AXES);
    assign w_slot   = WP_W'(in_slot);
    assign cm_we    = s_accept && wr_ok && (in_func == FUNC_WP || in_func == FUNC_COEF);
    assign tm_we    = s_accept && wr_ok && (in_func == FUNC_WP);
    assign cm_waddr = {row_of(w_slot, AXW'(in_axis)),
                       (in_func == FUNC_WP) ? POS_SLOT : {1'b0, in_cs}};

    // waypoint count clamped to 2..MAX_WAYPOINTS
    always_comb begin
        cnt_raw = CMP_W'(r_count);
        if (cnt_raw < CMP_W'(2)) begin
            cnt_c = CMP_W'(2);
        end else if (cnt_raw > CMP_W'(MAX_WAYPOINTS)) begin
            cnt_c = CMP_W'(MAX_WAYPOINTS);
        end else begin
            cnt_c = cnt_raw;
        end
    end

    assign last_wp   = WP_W'(cnt_c - CMP_W'(1));
    assign seg_max   = WP_W'(cnt_c - CMP_W'(2));
    assign seg_clamp = (r_cur_seg > seg_max) ? seg_max : r_cur_seg;
    assign seg_nx    = r_seg + WP_W'(1);
    assign order_n   = (r_mode == MODE_SPLINE) ? 3'd3 : {r_mode, 1'b1};
    // spline rows are per axis; blend polynomials sit in the axis 0 row
    assign cur_row   = row_of(r_seg, (r_mode == MODE_SPLINE) ? r_ax : AXW'(0));
    assign use_poly  = (r_mode == MODE_SPLINE) && !r_hold;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign last_ax   = (r_ax == AXW'(AXES - 1));
    assign wt_ext    = {r_tm_rd[31], r_tm_rd};
    assign s_axis_tready = (r_state == ST_IDLE);

    // ---------------- next state and memory/multiplier control ----------------
    always_comb begin
        n_state       = r_state;
        cm_re         = 1'b0;
        cm_raddr      = '0;
        tm_re         = 1'b0;
        tm_raddr      = '0;
        mul_req.start = 1'b0;
        mul_req.sh32  = 1'b0;
        mul_a         = r_acc;
        mul_b         = 64'(r_dt);
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_accept && in_func == FUNC_QUERY) begin
                    n_state = (!r_enable || in_time > r_finish) ? ST_HRD : ST_T1;
                end
            end
            ST_T1: begin
                tm_re    = 1'b1;
                tm_raddr = WP_W'(1);
                n_state  = ST_T1W;
            end
            ST_T1W: n_state = ST_SRCH;
            ST_SRCH: begin
                if (r_seg < seg_max) begin
                    tm_re    = 1'b1;
                    tm_raddr = r_seg;
                    n_state  = ST_SA;
                end else begin
                    n_state = ST_DT;
                end
            end
            ST_SA: begin
                tm_re    = 1'b1;
                tm_raddr = seg_nx;
                n_state  = ST_SB;
            end
            ST_SB: begin
                if (r_t >= 33'(r_wlo) && r_t < wt_ext) begin
                    n_state = ST_DT;
                end else begin
                    n_state = ST_SRCH;
                end
            end
            ST_DT: begin
                tm_re    = 1'b1;
                tm_raddr = r_seg;
                n_state  = ST_DTW;
            end
            ST_DTW: n_state = ST_EINIT;
            ST_EINIT: begin
                cm_re    = 1'b1;
                cm_raddr = {cur_row, 1'b0, order_n};
                n_state  = ST_EINITW;
            end
            ST_EINITW: n_state = ST_ESTEP;
            ST_ESTEP: begin
                if (r_k > 3'(r_ch)) begin
                    cm_re         = 1'b1;
                    cm_raddr      = {cur_row, 1'b0, r_k - 3'd1};
                    mul_req.start = 1'b1;
                    n_state       = ST_EMULW;
                end else if (r_ch == 2'd2) begin
                    n_state = (r_mode == MODE_SPLINE) ? ST_OUT : ST_BQ0;
                end else begin
                    n_state = ST_EINIT;
                end
            end
            ST_EMULW: begin
                if (mul_done) begin
                    n_state = ST_ESTEP;
                end
            end
            ST_BQ0: begin
                cm_re    = 1'b1;
                cm_raddr = {row_of(r_seg, r_ax), POS_SLOT};
                n_state  = ST_BQ0W;
            end
            ST_BQ0W: begin
                cm_re    = 1'b1;
                cm_raddr = {row_of(seg_nx, r_ax), POS_SLOT};
                n_state  = ST_BQFW;
            end
            ST_BQFW: n_state = ST_BM;
            ST_BM: begin
                mul_req.start = 1'b1;
                mul_req.sh32  = 1'b1;
                mul_a         = r_poly[r_j];
                mul_b         = r_dq;
                n_state       = ST_BMW;
            end
            ST_BMW: begin
                if (mul_done) begin
                    n_state = (r_j == 2'd2) ? ST_OUT : ST_BM;
                end
            end
            ST_HRD: begin
                cm_re    = 1'b1;
                cm_raddr = {row_of(last_wp, r_ax), POS_SLOT};
                n_state  = ST_HW;
            end
            ST_HW: n_state = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (last_ax) begin
                        n_state = ST_IDLE;
                    end else if (r_hold) begin
                        n_state = ST_HRD;
                    end else if (r_mode == MODE_SPLINE) begin
                        n_state = ST_EINIT;
                    end else begin
                        n_state = ST_BQ0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            r_cm[cm_waddr] <= in_value;
        end
        if (cm_re) begin
            r_cm_rd <= r_cm[cm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            r_tm[w_slot] <= in_time;
        end
        if (tm_re) begin
            r_tm_rd <= r_tm[tm_raddr];
        end
    end

    // ---------------- shared multiplier ----------------
    pti_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // remembered segment survives between queries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_seg <= '0;
        end else if (r_state == ST_DTW) begin
            r_cur_seg <= r_seg;
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_t    <= {in_time[31], in_time} - {r_start[31], r_start};
                r_hold <= !r_enable || (in_time > r_finish);
                r_ax   <= '0;
                r_ch   <= '0;
            end
            ST_T1W: begin
                // times before the second waypoint restart the search
                r_seg <= (r_t < wt_ext) ? '0 : seg_clamp;
            end
            ST_SA: r_wlo <= r_tm_rd;
            ST_SB: begin
                if (!(r_t >= 33'(r_wlo) && r_t < wt_ext)) begin
                    r_seg <= seg_nx;
                end
            end
            ST_DTW: r_dt <= 34'(r_t) - 34'(wt_ext);
            ST_EINITW: begin
                r_acc <= smulk(r_cm_rd, deriv_mult(order_n, r_ch));
                r_k   <= order_n;
            end
            ST_ESTEP: begin
                if (!(r_k > 3'(r_ch))) begin
                    r_poly[r_ch] <= r_acc;
                    r_ch         <= (r_ch == 2'd2) ? 2'd0 : r_ch + 2'd1;
                end
            end
            ST_EMULW: begin
                // coefficient term is ready long before the product
                r_term <= smulk(r_cm_rd, deriv_mult(r_k - 3'd1, r_ch));
                if (mul_done) begin
                    r_acc <= sadd64(mul_res, r_term);
                    r_k   <= r_k - 3'd1;
                end
            end
            ST_BQ0W: r_q0 <= r_cm_rd;
            ST_BQFW: begin
                r_dq <= ssub64(r_cm_rd, r_q0);
                r_j  <= '0;
            end
            ST_BMW: begin
                if (mul_done) begin
                    r_o[r_j] <= (r_j == 2'd0) ? sadd64(r_q0, mul_res) : mul_res;
                    r_j      <= r_j + 2'd1;
                end
            end
            ST_HW: begin
                r_o[0] <= r_enable ? r_cm_rd : 64'd0;
                r_o[1] <= '0;
                r_o[2] <= '0;
            end
            ST_OUT: begin
                if (out_free) begin
                    r_ax <= r_ax + AXW'(1);
                end
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ax   <= r_ax;
            r_out_last <= last_ax;
            r_out_p    <= use_poly ? r_poly[0] : r_o[0];
            r_out_v    <= use_poly ? r_poly[1] : r_o[1];
            r_out_a    <= use_poly ? r_poly[2] : r_o[2];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {5'd0, r_out_a, r_out_v, r_out_p, 3'(r_out_ax)};

    // ---------------- checks ----------------
    `PTI_ASSERT_IMP(a_mul_consumer, mul_done, (r_state == ST_EMULW) || (r_state == ST_BMW), "product with no waiting step")
    `PTI_ASSERT_IMP(a_chain_bound, r_state == ST_EMULW, r_k > 3'(r_ch), "Horner step past the chain end")
    `PTI_ASSERT_NEXT(a_out_load, out_load, r_out_valid, "result beat not registered")
    `PTI_ASSERT_NEXT(a_query_start, s_accept && (in_func == FUNC_QUERY), (r_state == ST_HRD) || (r_state == ST_T1), "query did not start")

endmodule

// ===== bench/tb_polynomial_trajectory_interpolator.sv =====
module tb_polynomial_trajectory_interpolator;
    import pti_pkg::*;

    typedef logic signed [63:0] s64;

    // func code that the block leaves unused
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int NAX = 6;
    localparam int NWP = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN = 60;

    typedef struct {
        logic [2:0] axis_no;
        s64         pos;
        s64         vel;
        s64         acc;
        logic       last;
    } axis_sample_t;

    // Trajectory predictor plus the queue of per-axis samples still owed by the block.
    class traj_scoreboard;
        logic [1:0] mode;
        logic [6:0] count;
        s64         t_start;
        s64         t_finish;
        logic       enable;
        s64         wp_time[NWP];
        s64         wp_pos[NWP*NAX];
        s64         coef[NWP*NAX*8];
        int         seg_now;
        axis_sample_t owed[$];
        int         errors;

        function new();
            mode = MODE_SPLINE;
            count = 7'd2;
            t_start = 0;
            t_finish = 0;
            enable = 1'b0;
            seg_now = 0;
            errors = 0;
        endfunction

        function s64 sat_add(s64 a, s64 b);
            logic [64:0] r;
            r = {a[63], a} + {b[63], b};
            if (r[64] != r[63]) return r[64] ? S64_MIN : S64_MAX;
            return r[63:0];
        endfunction

        function s64 sat_sub(s64 a, s64 b);
            logic [64:0] r;
            r = {a[63], a} - {b[63], b};
            if (r[64] != r[63]) return r[64] ? S64_MIN : S64_MAX;
            return r[63:0];
        endfunction

        // floor(a*b / 2^sh), saturated
        function s64 mul_shift(s64 a, s64 b, int sh);
            logic signed [127:0] p;
            logic signed [127:0] q;
            p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
            q = p >>> sh;
            if (q[127:63] != {65{q[127]}}) return q[127] ? S64_MIN : S64_MAX;
            return q[63:0];
        endfunction

        function s64 scale_k(s64 a, int k);
            s64 kk;
            kk = 64'(k) << 16;
            return mul_shift(a, kk, 16);
        endfunction

        // Horner for value, slope and curvature, highest power first
        function void horner(input s64 c[8], input int n, input s64 dt,
                             output s64 v, output s64 d1, output s64 d2);
            v = c[n];
            d1 = scale_k(c[n], n);
            d2 = scale_k(c[n], n * (n - 1));
            for (int k = n - 1; k >= 0; k--) v = sat_add(mul_shift(v, dt, 16), c[k]);
            for (int k = n - 1; k >= 1; k--)
                d1 = sat_add(mul_shift(d1, dt, 16), scale_k(c[k], k));
            for (int k = n - 1; k >= 2; k--)
                d2 = sat_add(mul_shift(d2, dt, 16), scale_k(c[k], k * (k - 1)));
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] data);
            case (addr)
                REG_MODE:   mode = data[1:0];
                REG_COUNT:  count = data[6:0];
                REG_START:  t_start = s64'($signed(data));
                REG_FINISH: t_finish = s64'($signed(data));
                REG_ENABLE: enable = data[0];
                default: ;
            endcase
        endfunction

        function void note_beat(logic [1:0] func, logic [5:0] slot, logic [2:0] ax,
                                logic [2:0] cs, logic [31:0] tv_raw, s64 val);
            int cnt, nseg, seg, order, base;
            s64 tv, t, dt, q0, qf, dq, p, v, a, pt, dpt, ddpt;
            s64 c[8];
            axis_sample_t smp;
            tv = s64'($signed(tv_raw));
            if (func == FUNC_WP || func == FUNC_COEF) begin
                if (ax < NAX) begin
                    if (func == FUNC_WP) begin
                        wp_time[slot] = tv;
                        wp_pos[slot*NAX + ax] = val;
                    end else begin
                        coef[(slot*NAX + ax)*8 + cs] = val;
                    end
                end
                return;
            end
            if (func != FUNC_QUERY) return;
            cnt = (count < 2) ? 2 : ((count > NWP) ? NWP : int'(count));
            nseg = cnt - 1;
            // disabled or past finish: hold last waypoint (or zeros), rates zero
            if (!enable || tv > t_finish) begin
                for (int i = 0; i < NAX; i++) begin
                    smp.axis_no = 3'(i);
                    smp.pos = enable ? wp_pos[(cnt-1)*NAX + i] : 64'sd0;
                    smp.vel = 0;
                    smp.acc = 0;
                    smp.last = (i == NAX - 1);
                    owed.push_back(smp);
                end
                return;
            end
            t = tv - t_start;
            seg = seg_now;
            if (seg > nseg - 1) seg = nseg - 1;
            if (t < wp_time[1]) seg = 0;
            while (seg < nseg - 1) begin
                if (t >= wp_time[seg] && t < wp_time[seg+1]) break;
                seg++;
            end
            seg_now = seg;
            dt = t - wp_time[seg];
            for (int i = 0; i < NAX; i++) begin
                if (mode == MODE_SPLINE) begin
                    base = (seg*NAX + i)*8;
                    for (int j = 0; j < 8; j++) c[j] = coef[base + j];
                    horner(c, 3, dt, p, v, a);
                end else begin
                    order = 2*int'(mode) + 1;
                    base = seg*NAX*8;
                    for (int j = 0; j < 8; j++) c[j] = coef[base + j];
                    q0 = wp_pos[seg*NAX + i];
                    qf = wp_pos[(seg+1)*NAX + i];
                    dq = sat_sub(qf, q0);
                    horner(c, order, dt, pt, dpt, ddpt);
                    p = sat_add(q0, mul_shift(pt, dq, 32));
                    v = mul_shift(dpt, dq, 32);
                    a = mul_shift(ddpt, dq, 32);
                end
                smp.axis_no = 3'(i);
                smp.pos = p;
                smp.vel = v;
                smp.acc = a;
                smp.last = (i == NAX - 1);
                owed.push_back(smp);
            end
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH @%0t: %s", $time, what);
        endtask

        task check_result(logic [2:0] ax, s64 pos, s64 vel, s64 acc, logic last);
            axis_sample_t e;
            if (owed.size() == 0) begin
                report($sformatf("unexpected beat axis %0d", ax));
                return;
            end
            e = owed.pop_front();
            if (ax !== e.axis_no) report($sformatf("axis %0d, want %0d", ax, e.axis_no));
            if (pos !== e.pos)
                report($sformatf("axis %0d position %h, want %h", e.axis_no, pos, e.pos));
            if (vel !== e.vel)
                report($sformatf("axis %0d velocity %h, want %h", e.axis_no, vel, e.vel));
            if (acc !== e.acc)
                report($sformatf("axis %0d accel %h, want %h", e.axis_no, acc, e.acc));
            if (last !== e.last) report($sformatf("axis %0d tlast %b", e.axis_no, last));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // slot, axis, coef_slot, time_value, value
    logic [1:0]             s_axis_tuser;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // axis_out, position, velocity, acceleration
    logic                   m_axis_tlast;
    logic                   i_cfg_we;
    logic [2:0]             i_cfg_addr;
    logic [31:0]            i_cfg_wdata;

    traj_scoreboard sb;
    int tx_max_gap;
    int rx_max_gap;
    int cycles;

    polynomial_trajectory_interpolator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // hard stop on a hung block
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // mostly moderate values, now and then a full 64-bit pattern to hit saturation
    function automatic s64 rand_val();
        s64 r;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) return r;
        return r >>> 24;
    endfunction

    // one input beat; the predictor sees it at the accepting edge
    task automatic send_beat(logic [1:0] func, logic [5:0] slot, logic [2:0] ax,
                             logic [2:0] cs, logic [31:0] tv, s64 val);
        int gap;
        gap = tx_max_gap ? $urandom_range(0, tx_max_gap) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {4'd0, val, tv, cs, ax, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(func, slot, ax, cs, tv, val);
    endtask

    // stop sending and let every owed beat drain before touching registers
    task automatic go_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(addr, data);
    endtask

    // waypoints 0..n-1 on every axis, then coefficients for every segment:
    // axis 0 gets all eight powers (blend), the others the cubic ones
    task automatic load_traj(int n);
        logic [31:0] t;
        t = $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 32'h40000)) - 32'h20000);
        for (int i = 0; i < n; i++) begin
            for (int a = 0; a < NAX; a++) send_beat(FUNC_WP, 6'(i), 3'(a), 3'd0, t, rand_val());
            t = t + $urandom_range(32'h100, 32'h30000);
        end
        for (int s = 0; s < n - 1; s++)
            for (int a = 0; a < NAX; a++)
                for (int k = 0; k < ((a == 0) ? 8 : 4); k++)
                    send_beat(FUNC_COEF, 6'(s), 3'(a), 3'(k), {$urandom}, rand_val());
    endtask

    // queries around the loaded waypoints, with some rewrites and noise mixed in
    task automatic run_queries(int k);
        int cnt, i, r;
        logic [31:0] tv;
        cnt = (sb.count < 2) ? 2 : ((sb.count > NWP) ? NWP : int'(sb.count));
        repeat (k) begin
            r = $urandom_range(0, 19);
            i = $urandom_range(0, cnt - 1);
            tv = 32'(sb.t_start + sb.wp_time[i]) + $urandom_range(0, 32'h30000) - 32'h8000;
            case (r)
                0: tv = $urandom;
                1: tv = 32'(sb.t_finish) + $urandom_range(1, 32'h10000);
                default: ;
            endcase
            if (r == 2)
                send_beat(FUNC_COEF, 6'($urandom_range(0, NWP - 1)), 3'($urandom_range(0, NAX - 1)),
                          3'($urandom), $urandom, rand_val());
            else if (r == 3)
                send_beat(2'($urandom_range(0, 1)), 6'($urandom), 3'($urandom_range(6, 7)),
                          3'($urandom), $urandom, rand_val());
            else if (r == 4)
                send_beat(FUNC_NONE, 6'($urandom), 3'($urandom), 3'($urandom), $urandom, rand_val());
            else
                send_beat(FUNC_QUERY, 6'($urandom), 3'($urandom), 3'($urandom), tv, rand_val());
        end
    endtask

    // output side: random stalls per beat, checked at the accepting edge
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = rx_max_gap ? $urandom_range(0, rx_max_gap) : 0;
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata[2:0], m_axis_tdata[66:3], m_axis_tdata[130:67],
                            m_axis_tdata[194:131], m_axis_tlast);
        end
    end

    initial begin
        int cnt;
        sb = new();
        cycles = 0;
        tx_max_gap = 16;
        rx_max_gap = 16;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_NONE;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_MODE;
        i_cfg_wdata = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: disabled query gives zeros, unused func and bad axis do nothing
        send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'h8000_0000, S64_MIN);
        send_beat(FUNC_NONE, 6'h3F, 3'd7, 3'd7, 32'hFFFF_FFFF, S64_MAX);
        send_beat(FUNC_WP, 6'd1, 3'd6, 3'd0, 32'h1234, S64_MAX);
        send_beat(FUNC_COEF, 6'd0, 3'd7, 3'd7, 32'h0, S64_MIN);
        load_traj(3);
        go_idle();
        cfg_write(REG_MODE, MODE_SPLINE);
        cfg_write(REG_COUNT, 32'd3);
        cfg_write(REG_START, 32'd0);
        cfg_write(REG_FINISH, 32'h7FFF_FFFF);
        cfg_write(REG_ENABLE, 32'd1);
        // time extremes, each waypoint time, and saturating coefficients
        send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'h8000_0000, 64'sd0);
        send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'h7FFF_FFFF, 64'sd0);
        for (int i = 0; i < 3; i++)
            send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'(sb.wp_time[i]), 64'sd0);
        send_beat(FUNC_COEF, 6'd0, 3'd2, 3'd3, 32'd0, S64_MAX);
        send_beat(FUNC_COEF, 6'd0, 3'd3, 3'd0, 32'd0, S64_MIN);
        send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'(sb.wp_time[1]) - 32'd1, 64'sd0);
        for (int m = 1; m < 4; m++) begin
            go_idle();
            cfg_write(REG_MODE, 32'(m));
            send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'(sb.wp_time[1]) + 32'h800, 64'sd0);
        end
        // hold past finish time
        go_idle();
        cfg_write(REG_FINISH, 32'h8000_0000);
        send_beat(FUNC_QUERY, 6'd0, 3'd0, 3'd0, 32'h0, 64'sd0);

        // full-size trajectory once, so every entry a query reads is written from here on
        go_idle();
        tx_max_gap = 2;
        load_traj(NWP);
        tx_max_gap = 16;

        for (int ph = 0; ph < 12; ph++) begin
            go_idle();
            if (ph > 0 && $urandom_range(0, 2) == 0) begin
                tx_max_gap = 2;
                load_traj($urandom_range(2, 6));
                tx_max_gap = 16;
                go_idle();
            end
            case (ph)
                0: cnt = NWP;
                1: cnt = 0;
                2: cnt = 127;
                3: cnt = 1;
                default: cnt = $urandom_range(2, 6);
            endcase
            cfg_write(REG_MODE, (ph < 4) ? 32'(ph) : 32'($urandom_range(0, 3)));
            cfg_write(REG_COUNT, 32'(cnt));
            case (ph % 4)
                0: cfg_write(REG_START, 32'h8000_0000);
                1: cfg_write(REG_START, 32'h7FFF_FFFF);
                default: cfg_write(REG_START, $urandom_range(0, 1) ? 32'd0 : $urandom);
            endcase
            cnt = (sb.count < 2) ? 2 : ((sb.count > NWP) ? NWP : int'(sb.count));
            if (ph == 5) cfg_write(REG_FINISH, 32'h8000_0000);
            else if (ph == 6) cfg_write(REG_FINISH, 32'h7FFF_FFFF);
            else cfg_write(REG_FINISH, 32'(sb.t_start + sb.wp_time[cnt-1]) + $urandom_range(0, 32'h20000));
            cfg_write(REG_ENABLE, (ph == 7) ? 32'd0 : 32'd1);
            // some phases run without any back-pressure or gaps
            tx_max_gap = (ph % 3 == 2) ? 0 : 16;
            rx_max_gap = (ph % 4 == 3) ? 0 : 16;
            run_queries((ph < 3) ? 15 : 35);
        end

        go_idle();
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
